/* hw/rtl/fe7pk_pkg.sv */
// Shared types and constants for the framed 8-to-7 bit packer.
// No dependencies; imported by every other file of the block but fe7pk_ifs.
package fe7pk_pkg;

  localparam logic [7:0] START_MARK = 8'hF0;
  localparam logic [7:0] END_MARK   = 8'hF7;
  localparam logic [6:0] SEVEN_MASK = 7'h7F;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Up to two output bytes produced by one input item.
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
  } pair_t;

endpackage

/* hw/rtl/fe7pk_ifs.sv */
// Valid/ready channel interfaces for the packer's input and output streams.
// No dependencies.
interface fe7pk_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface fe7pk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* hw/rtl/fe7pk_step.sv */
// Packing logic and carried residue state: turns one item into one or two bytes.
// Depends on fe7pk_pkg.
module fe7pk_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            kind,
  input  logic [7:0]      data_byte,
  output fe7pk_pkg::pair_t pair
);
  import fe7pk_pkg::*;

  logic [5:0]  residue_bits;
  logic [2:0]  residue_count;
  logic        frame_open;
  logic [5:0]  residue_bits_next;
  logic [2:0]  residue_count_next;
  logic        frame_open_next;

  logic [2:0]  cnt;
  logic [5:0]  acc;
  logic [13:0] comb;

  always_comb begin
    cnt  = (residue_count > 3'd6) ? 3'd6 : residue_count;
    acc  = residue_bits & 6'((7'd1 << cnt) - 7'd1);
    comb = {8'd0, acc} | (14'(data_byte) << cnt);

    pair               = '0;
    residue_bits_next  = residue_bits;
    residue_count_next = residue_count;
    frame_open_next    = frame_open;

    if (kind == KIND_DATA) begin
      frame_open_next = 1'b1;
      if (!frame_open) begin
        pair.two   = 1'b1;
        pair.byte0 = START_MARK;
        pair.byte1 = {1'b0, comb[6:0] & SEVEN_MASK};
      end else if (cnt == 3'd6) begin
        pair.two   = 1'b1;
        pair.byte0 = {1'b0, comb[6:0]};
        pair.byte1 = {1'b0, comb[13:7]};
      end else begin
        pair.byte0 = {1'b0, comb[6:0]};
      end
      // a full 14 bits leaves nothing carried
      if (frame_open && cnt == 3'd6) begin
        residue_bits_next  = '0;
        residue_count_next = '0;
      end else begin
        residue_bits_next  = comb[12:7];
        residue_count_next = cnt + 3'd1;
      end
    end else begin
      if (!frame_open || cnt != 3'd0) begin
        pair.two   = 1'b1;
        pair.byte0 = frame_open ? {2'b00, acc} : START_MARK;
        pair.byte1 = END_MARK;
        pair.last1 = 1'b1;
      end else begin
        pair.byte0 = END_MARK;
        pair.last0 = 1'b1;
      end
      residue_bits_next  = '0;
      residue_count_next = '0;
      frame_open_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residue_bits  <= '0;
      residue_count <= '0;
      frame_open    <= 1'b0;
    end else if (advance) begin
      residue_bits  <= residue_bits_next;
      residue_count <= residue_count_next;
      frame_open    <= frame_open_next;
    end
  end

endmodule

/* hw/rtl/fe7pk_out_buf.sv */
// Result register holding one byte pair and sending it out one byte at a time.
// Depends on fe7pk_pkg and fe7pk_out_if.
module fe7pk_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  fe7pk_pkg::pair_t load_pair,
  output logic             load_ready,
  fe7pk_out_if.source      out_ch
);
  import fe7pk_pkg::*;

  pair_t pair;
  logic  pvalid;
  logic  sel;
  logic  done;

  assign out_ch.valid    = pvalid;
  assign out_ch.out_byte = sel ? pair.byte1 : pair.byte0;
  assign out_ch.last     = sel ? pair.last1 : pair.last0;

  // pair leaves when its final byte is taken
  assign done       = pvalid && out_ch.ready && (sel || !pair.two);
  assign load_ready = !pvalid || done;

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      pair <= load_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      sel    <= 1'b0;
    end else if (load_valid && load_ready) begin
      pvalid <= 1'b1;
      sel    <= 1'b0;
    end else if (done) begin
      pvalid <= 1'b0;
      sel    <= 1'b0;
    end else if (pvalid && out_ch.ready) begin
      sel <= 1'b1;
    end
  end

endmodule

/* hw/rtl/framed_eight_to_seven_bit_packer_core.sv */
// Framed 8-to-7 bit packer: top level with input register, packing step and output buffer.
// Depends on fe7pk_pkg, fe7pk_ifs, fe7pk_step and fe7pk_out_buf.
//
// Usage:
//   in_ch carries requests: kind 0 is a message data byte, kind 1 closes the
//   message. out_ch carries bytes: 0xF0 opens each frame, the data bits follow
//   repacked LSB first into 7-bit bytes, and 0xF7 with last high closes it.
//   An empty message gives 0xF0 then 0xF7.
// Path: a request goes through the input register and then the output buffer
//   register before its first byte is valid on out_ch.
// Throughput: a request yields one or two bytes; the output buffer sends one
//   byte a cycle while out_ch is ready, and a request making two bytes holds
//   back the next one until both are taken. The output port sets the rate.
// Reset: rst (synchronous) empties the input and output registers and clears
//   the carried residue bits and the open-frame flag.
// Stall: when out_ch is not ready the byte on it holds; the input register
//   still takes one more request, then in_ch.ready drops until the output
//   buffer frees.
module framed_eight_to_seven_bit_packer_core (
  input  logic        clk,
  input  logic        rst,
  fe7pk_in_if.sink    in_ch,
  fe7pk_out_if.source out_ch
);
  import fe7pk_pkg::*;

  logic       stage_valid;
  logic       stage_kind;
  logic [7:0] stage_data;
  logic       load_ready;
  logic       advance;
  pair_t      step_pair;

  assign advance     = stage_valid && load_ready;
  assign in_ch.ready = !stage_valid || load_ready;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_kind <= in_ch.kind;
      stage_data <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  fe7pk_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .kind      (stage_kind),
    .data_byte (stage_data),
    .pair      (step_pair)
  );

  fe7pk_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load_valid (stage_valid),
    .load_pair  (step_pair),
    .load_ready (load_ready),
    .out_ch     (out_ch)
  );

endmodule

/* tb/sv/packer_scoreboard.sv */
// Scoreboard for the framed 8-to-7 bit packer: predicts output bytes from accepted requests.
// Depends on fe7pk_pkg and the channel interfaces in fe7pk_ifs.
`timescale 1ns / 100ps

module packer_scoreboard
  import fe7pk_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  fe7pk_in_if   in_ch,
  fe7pk_out_if  out_ch,
  output int    mismatches,
  output int    outstanding,
  output int    checked
);

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
  } packed_byte_t;

  packed_byte_t expected_bytes[$];

  // Packer state as the block should hold it.
  logic [5:0] carry_bits;
  logic [2:0] carry_cnt;
  logic       frame_open;

  task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: result %0d %s expected 0x%02h got 0x%02h", $realtime, checked, field,
             want, got);
    mismatches++;
  endtask

  function automatic void queue_byte(input logic [7:0] b, input logic l);
    packed_byte_t e;
    e.out_byte = b;
    e.last     = l;
    expected_bytes.push_back(e);
  endfunction

  // Work out the bytes that one request must produce and advance the state.
  function automatic void pack_request(input logic k, input logic [7:0] b);
    logic [13:0] acc;
    int unsigned cnt;
    cnt = (carry_cnt > 3'd6) ? 6 : carry_cnt;
    acc = {8'h00, carry_bits} & ((14'd1 << cnt) - 14'd1);
    if (k == KIND_DATA) begin
      if (!frame_open) begin
        queue_byte(START_MARK, 1'b0);
        frame_open = 1'b1;
      end
      acc = acc | (14'(b) << cnt);
      cnt = cnt + 8;
      while (cnt >= 7) begin
        queue_byte({1'b0, acc[6:0] & SEVEN_MASK}, 1'b0);
        acc = acc >> 7;
        cnt = cnt - 7;
      end
      carry_bits = acc[5:0];
      carry_cnt  = 3'(cnt);
    end else begin
      if (!frame_open)
        queue_byte(START_MARK, 1'b0);
      else if (cnt != 0)
        queue_byte({1'b0, acc[6:0] & SEVEN_MASK}, 1'b0);
      queue_byte(END_MARK, 1'b1);
      carry_bits = '0;
      carry_cnt  = '0;
      frame_open = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    packed_byte_t e;
    if (rst) begin
      expected_bytes.delete();
      carry_bits = '0;
      carry_cnt  = '0;
      frame_open = 1'b0;
    end else begin
      // Results of a request appear later, so retire before adding new ones.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          report("out_byte with nothing pending", 8'h00, out_ch.out_byte);
        end else begin
          e = expected_bytes.pop_front();
          if (out_ch.out_byte !== e.out_byte)
            report("out_byte", e.out_byte, out_ch.out_byte);
          if (out_ch.last !== e.last)
            report("last", {7'h00, e.last}, {7'h00, out_ch.last});
        end
        checked++;
      end
      if (in_ch.valid && in_ch.ready)
        pack_request(in_ch.kind, in_ch.data_byte);
    end
    outstanding <= expected_bytes.size();
  end

endmodule

/* tb/sv/framed_eight_to_seven_bit_packer_core_tb.sv */
// Top-level testbench for the framed 8-to-7 bit packer: drives framed messages with bursty
// input and a stalling receiver. Depends on fe7pk_pkg, fe7pk_ifs and packer_scoreboard.
`timescale 1ns / 100ps

module framed_eight_to_seven_bit_packer_core_tb;
  import fe7pk_pkg::*;

  localparam int ITEM_TARGET = 1450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_output;
  int   items_sent = 0;
  int   frames_sent = 0;
  int   burst_left = 0;
  int   mismatches, outstanding, checked;

  always #4 clk = ~clk;

  fe7pk_in_if  in_ch ();
  fe7pk_out_if out_ch ();

  framed_eight_to_seven_bit_packer_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  packer_scoreboard pack_check (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Offer one request, with a random gap first when the current burst is used up.
  task automatic put_request(input logic k, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= k;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$], input logic [7:0] tail);
    foreach (msg[i])
      put_request(KIND_DATA, msg[i]);
    put_request(KIND_END, tail);
    frames_sent++;
  endtask

  // Stimulus
  initial begin
    logic [7:0] msg[$];
    int len, pick;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_DATA;
    in_ch.data_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty frames, single extreme bytes, full residue, ignored tail byte.
    msg = {};
    send_message(msg, 8'h00);
    send_message(msg, 8'hA5);
    msg = '{8'h00};
    send_message(msg, 8'hFF);
    msg = '{8'hFF};
    send_message(msg, 8'h00);
    msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message(msg, 8'h5A);
    msg = '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h80, 8'h01};
    send_message(msg, 8'hFF);

    // Random frames: mostly short, some long, some empty.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        len = 0;
      else if (pick < 85)
        len = $urandom_range(1, 14);
      else
        len = $urandom_range(15, 60);
      msg = {};
      repeat (len) begin
        pick = $urandom_range(0, 9);
        msg.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
      end
      send_message(msg, 8'($urandom));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests in %0d frames; %0d output bytes compared.", items_sent,
             frames_sent, checked);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Receiver: stall pattern changes mode every stretch.
  initial begin
    int mode, stretch;
    logic take;
    out_ch.ready <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 60);
      repeat (stretch) begin
        case (mode)
          0: take = 1'b1;
          1: take = 1'($urandom_range(0, 1));
          2: take = ($urandom_range(0, 3) != 0);
          default: take = ($urandom_range(0, 3) == 0);
        endcase
        out_ch.ready <= take && !hold_output;
        @(posedge clk);
      end
    end
  end

  // Long receiver hold-off so the block backs up and drops in_ch.ready.
  initial begin
    hold_output <= 1'b0;
    wait (!rst);
    repeat (400) @(posedge clk);
    hold_output <= 1'b1;
    repeat (200) @(posedge clk);
    hold_output <= 1'b0;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fe7pk_pkg.sv
hw/rtl/fe7pk_ifs.sv
hw/rtl/fe7pk_step.sv
hw/rtl/fe7pk_out_buf.sv
hw/rtl/framed_eight_to_seven_bit_packer_core.sv
tb/sv/packer_scoreboard.sv
tb/sv/framed_eight_to_seven_bit_packer_core_tb.sv
